// ----- sv/ffha_pkg.sv -----
// Package: shared constants, state codes and status codes of the heap allocator.
package ffha_pkg;
    localparam int HEAP_BYTES   = 1024;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W       = $clog2(HEAP_BYTES + 1);
    localparam int ENTRY_W      = SIZE_W + 1;
    localparam int ADDR_W       = $clog2(HEAP_BYTES + HEADER_BYTES + 1) + 1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
    localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SPLIT,
        S_MERGE_R,
        S_CHECK_R,
        S_MERGE_L,
        S_CHECK_L,
        S_SHIFT_DN,
        S_DONE
    } t_state;
endpackage

// ----- sv/first_fit_heap_allocator.sv -----
// Top level: block table, scan and edit sequencer of the first-fit heap allocator.
//
//  channel | dir | fields
//  s_axis  | in  | tuser = kind, tdata = request_bytes, release_offset
//  m_axis  | out | tdata = status, payload_offset
//
// The table is a memory of {free, size} words with one registered read and one
// write per cycle. An accepted item scans one entry a cycle up to the hit. A split
// moves the tail up one entry a cycle and writes the block back; a free checks each
// neighbor, and each merge moves the tail down one entry a cycle; reset leaves one
// free block, and the block takes no word until the result word is taken.
module first_fit_heap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [9:0] request_bytes, [19:10] release_offset
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [1:0] status, [11:2] payload_offset
);
    import ffha_pkg::*;

    logic [ENTRY_W-1:0] r_tbl [MAX_BLOCKS];   // {free, size}
    logic [ENTRY_W-1:0] r_rd;                 // registered read word
    logic [IDX_W-1:0]   rd_idx;
    logic               rd_free;
    logic [SIZE_W-1:0]  rd_size;

    logic [CNT_W-1:0] r_count, n_count;
    t_state r_state, n_state;
    logic r_kind;
    logic [9:0] r_req, r_rel;
    logic [IDX_W-1:0] r_i, n_i;     // block being worked on
    logic [IDX_W-1:0] r_j, n_j;     // tail move pointer
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [SIZE_W-1:0] r_cur, n_cur; // size of block i while merging
    logic [SIZE_W-1:0] r_rest, n_rest;
    logic [1:0] r_status, n_status;
    logic [9:0] r_off, n_off;

    // one entry written per cycle
    logic               w_en;
    logic [IDX_W-1:0]   w_idx;
    logic [ENTRY_W-1:0] w_data;

    logic [ADDR_W-1:0] pay;
    logic [IDX_W-1:0]  i_p1, i_p2, i_m1, j_p1, j_p2, j_m1, j_m2, last;
    logic [SIZE_W:0]   req_hdr;
    logic [SIZE_W-1:0] merged;
    logic              fits, can_split, is_last, has_right, hit_rel;

    assign rd_free   = r_rd[SIZE_W];
    assign rd_size   = r_rd[SIZE_W-1:0];
    assign pay       = r_addr + ADDR_W'(HEADER_BYTES);
    assign i_p1      = r_i + 1'b1;
    assign i_p2      = r_i + 2'd2;
    assign i_m1      = r_i - 1'b1;
    assign j_p1      = r_j + 1'b1;
    assign j_p2      = r_j + 2'd2;
    assign j_m1      = r_j - 1'b1;
    assign j_m2      = r_j - 2'd2;
    assign last      = IDX_W'(r_count - 1'b1);
    assign req_hdr   = (SIZE_W+1)'(r_req) + (SIZE_W+1)'(HEADER_BYTES);
    // single shared adder of the merge steps: block i plus the neighbor just read
    assign merged    = r_cur + SIZE_W'(HEADER_BYTES) + rd_size;
    assign fits      = rd_free && (rd_size >= SIZE_W'(r_req));
    assign can_split = ({1'b0, rd_size} > req_hdr) && (r_count < CNT_W'(MAX_BLOCKS));
    assign is_last   = (r_i == last);
    assign has_right = ((CNT_W'(r_i) + 1'b1) < r_count);
    assign hit_rel   = (pay == ADDR_W'(r_rel));

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_DONE);
    assign m_axis_tdata  = {4'd0, r_off, r_status};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == KIND_FREE && s_axis_tdata[19:10] == 10'd0)
                        n_state = S_DONE;
                    else
                        n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_kind == KIND_ALLOC) begin
                    if (fits)
                        n_state = can_split ? S_SHIFT_UP : S_DONE;
                    else if (is_last)
                        n_state = S_DONE;
                end else begin
                    if (hit_rel)
                        n_state = S_MERGE_R;
                    else if (is_last)
                        n_state = S_DONE;
                end
            end
            S_SHIFT_UP: begin
                if (r_j == i_p1) n_state = S_SPLIT;
            end
            S_SPLIT:    n_state = S_DONE;
            S_MERGE_R:  n_state = has_right ? S_CHECK_R : S_MERGE_L;
            S_CHECK_R:  n_state = rd_free ? S_SHIFT_DN : S_MERGE_L;
            S_MERGE_L:  n_state = (r_i != '0) ? S_CHECK_L : S_DONE;
            S_CHECK_L:  n_state = rd_free ? S_SHIFT_DN : S_DONE;
            S_SHIFT_DN: begin
                if (r_j == last) n_state = S_MERGE_R;
            end
            S_DONE: begin
                if (m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count; n_i = r_i; n_j = r_j; n_addr = r_addr; n_cur = r_cur;
        n_rest = r_rest; n_status = r_status; n_off = r_off;
        w_en = 1'b0; w_idx = r_i; w_data = r_rd;
        rd_idx = i_p1;
        unique case (r_state)
            S_IDLE: begin
                n_i = '0; n_addr = '0; n_status = STATUS_OK; n_off = '0;
                rd_idx = '0;
            end
            S_SCAN: begin
                if (r_kind == KIND_ALLOC) begin
                    if (fits) begin
                        n_off = pay[9:0];
                        if (can_split) begin
                            n_rest = SIZE_W'({1'b0, rd_size} - req_hdr);
                            n_j = IDX_W'(r_count);
                            rd_idx = last;
                        end else begin
                            w_en = 1'b1; w_data = {1'b0, rd_size};
                        end
                    end else if (is_last) begin
                        n_status = STATUS_NO_FIT;
                    end else begin
                        n_i = i_p1;
                        n_addr = r_addr + ADDR_W'(HEADER_BYTES) + ADDR_W'(rd_size);
                    end
                end else begin
                    if (hit_rel) begin
                        w_en = 1'b1; w_data = {1'b1, rd_size};
                        n_cur = rd_size;
                    end else if (is_last) begin
                        n_status = STATUS_BAD_ADDR;
                    end else begin
                        n_i = i_p1;
                        n_addr = r_addr + ADDR_W'(HEADER_BYTES) + ADDR_W'(rd_size);
                    end
                end
            end
            S_SHIFT_UP: begin
                // move entry j-1 to j until j reaches i+1, then place the remainder
                w_en = 1'b1; w_idx = r_j;
                if (r_j == i_p1) begin
                    w_data = {1'b1, r_rest};
                    n_count = r_count + 1'b1;
                end else begin
                    w_data = r_rd; rd_idx = j_m2; n_j = j_m1;
                end
            end
            S_SPLIT: begin
                w_en = 1'b1; w_data = {1'b0, SIZE_W'(r_req)};
            end
            S_MERGE_R: begin
                rd_idx = i_p1;
            end
            S_CHECK_R: begin
                if (rd_free) begin
                    w_en = 1'b1; w_data = {1'b1, merged};
                    n_cur = merged; n_j = i_p1; rd_idx = i_p2;
                end
            end
            S_MERGE_L: begin
                rd_idx = i_m1;
            end
            S_CHECK_L: begin
                if (rd_free) begin
                    w_en = 1'b1; w_idx = i_m1; w_data = {1'b1, merged};
                    n_cur = merged; n_j = r_i; n_i = i_m1; rd_idx = i_p1;
                end
            end
            S_SHIFT_DN: begin
                // close entry j by moving the tail down
                if (r_j == last) begin
                    n_count = r_count - 1'b1;
                end else begin
                    w_en = 1'b1; w_idx = r_j; w_data = r_rd;
                    n_j = j_p1; rd_idx = j_p2;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl[0] <= {1'b1, SIZE_W'(HEAP_BYTES - HEADER_BYTES)};
        end else if (w_en) begin
            r_tbl[w_idx] <= w_data;
        end
        r_rd <= r_tbl[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_kind <= s_axis_tuser;
            r_req  <= s_axis_tdata[9:0];
            r_rel  <= s_axis_tdata[19:10];
        end
        r_i <= n_i; r_j <= n_j; r_addr <= n_addr; r_cur <= n_cur; r_rest <= n_rest;
        r_status <= n_status; r_off <= n_off;
    end
endmodule
